// ===== sv/cdp0_pkg.sv =====
// Shared types and constants for the composition data page 0 parser.
// Used by cdp0_core, cdp0_fifo and composition_data_page0_parser.
package cdp0_pkg;

  // Header byte positions of the little-endian feature word.
  localparam logic [7:0] FEATURE_LO_POS = 8'd8;
  localparam logic [7:0] FEATURE_HI_POS = 8'd9;

  // Highest foundation model id; these SIG models are dropped.
  localparam logic [15:0] MAX_FOUNDATION_ID = 16'h0003;

  // Saturation value of the element counter.
  localparam logic [7:0] ELEMENT_MAX = 8'hFF;

  // Record kinds.
  localparam logic [1:0] KIND_FEATURES = 2'd0;
  localparam logic [1:0] KIND_SIG      = 2'd1;
  localparam logic [1:0] KIND_VENDOR   = 2'd2;
  localparam logic [1:0] KIND_END      = 2'd3;

  // Result queue geometry. The depth must be a power of two of at least 2.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LOC    = 3'd1,
    PH_NUMS   = 3'd2,
    PH_NUMV   = 3'd3,
    PH_SIG    = 3'd4,
    PH_VEND   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  element_index;
    logic [7:0]  model_slot;
    logic [15:0] model_id;
    logic [15:0] company_id;
    logic [15:0] feature_bits;
    logic [7:0]  element_count;
    logic        malformed;
    logic        last_result;
  } out_t;

  // Up to two records produced by one parse step: a feature or model record,
  // then the end of page record.
  typedef struct packed {
    logic rec_vld;
    logic fin_vld;
    out_t rec;
    out_t fin;
  } push_t;

endpackage

// ===== sv/cdp0_core.sv =====
// Parse state and per-byte step logic of the composition data page 0 parser.
// Depends on cdp0_pkg.
module cdp0_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  cdp0_pkg::in_t   item,
  output cdp0_pkg::push_t push
);

  logic [7:0]       byte_pos, byte_pos_next;
  cdp0_pkg::phase_t phase, phase_next;
  logic [7:0]       cur_elem, cur_elem_next;
  logic [7:0]       sig_left, sig_left_next;
  logic [7:0]       vend_left, vend_left_next;
  logic [1:0]       bif, bif_next;
  logic [23:0]      partial, partial_next;
  logic [7:0]       kept_slot, kept_slot_next;
  logic [15:0]      features, features_next;

  logic [15:0]      sig_id;
  logic [7:0]       end_count;
  logic             clean;
  logic             rec_vld;
  cdp0_pkg::out_t   rec;
  cdp0_pkg::out_t   fin;
  logic [7:0]       b;

  assign b = item.data_byte;
  assign sig_id = {b, partial[7:0]};

  always_comb begin
    byte_pos_next  = byte_pos;
    phase_next     = phase;
    cur_elem_next  = cur_elem;
    sig_left_next  = sig_left;
    vend_left_next = vend_left;
    bif_next       = bif;
    partial_next   = partial;
    kept_slot_next = kept_slot;
    features_next  = features;
    rec_vld        = 1'b0;
    rec            = '0;
    fin            = '0;
    clean          = 1'b0;
    end_count      = 8'd0;

    unique case (phase)
      cdp0_pkg::PH_HEADER: begin
        if (byte_pos == cdp0_pkg::FEATURE_LO_POS) begin
          features_next = {8'h00, b};
        end else if (byte_pos == cdp0_pkg::FEATURE_HI_POS) begin
          features_next    = {b, features[7:0]};
          rec_vld          = 1'b1;
          rec.record_kind  = cdp0_pkg::KIND_FEATURES;
          phase_next       = cdp0_pkg::PH_LOC;
          bif_next         = 2'd0;
        end
        byte_pos_next = byte_pos + 8'd1;
      end
      cdp0_pkg::PH_NUMS: begin
        sig_left_next = b;
        phase_next    = cdp0_pkg::PH_NUMV;
      end
      cdp0_pkg::PH_NUMV: begin
        vend_left_next = b;
        bif_next       = 2'd0;
        if (sig_left != 8'd0) begin
          phase_next = cdp0_pkg::PH_SIG;
        end else if (b != 8'd0) begin
          phase_next = cdp0_pkg::PH_VEND;
        end else begin
          cur_elem_next = (cur_elem != cdp0_pkg::ELEMENT_MAX) ? cur_elem + 8'd1 : cur_elem;
          phase_next    = cdp0_pkg::PH_LOC;
        end
      end
      cdp0_pkg::PH_SIG: begin
        if (bif == 2'd0) begin
          partial_next = {16'h0000, b};
          bif_next     = 2'd1;
        end else begin
          bif_next = 2'd0;
          if (sig_id > cdp0_pkg::MAX_FOUNDATION_ID) begin
            rec_vld           = 1'b1;
            rec.record_kind   = cdp0_pkg::KIND_SIG;
            rec.element_index = cur_elem;
            rec.model_slot    = kept_slot;
            rec.model_id      = sig_id;
            kept_slot_next    = kept_slot + 8'd1;
          end
          sig_left_next = sig_left - 8'd1;
          if (sig_left == 8'd1) begin
            if (vend_left != 8'd0) begin
              phase_next = cdp0_pkg::PH_VEND;
            end else begin
              cur_elem_next = (cur_elem != cdp0_pkg::ELEMENT_MAX) ? cur_elem + 8'd1
                                                                  : cur_elem;
              phase_next    = cdp0_pkg::PH_LOC;
            end
          end
        end
      end
      cdp0_pkg::PH_VEND: begin
        if (bif != 2'd3) begin
          unique case (bif)
            2'd0:    partial_next[7:0]   = b;
            2'd1:    partial_next[15:8]  = b;
            default: partial_next[23:16] = b;
          endcase
          bif_next = bif + 2'd1;
        end else begin
          bif_next          = 2'd0;
          rec_vld           = 1'b1;
          rec.record_kind   = cdp0_pkg::KIND_VENDOR;
          rec.element_index = cur_elem;
          rec.model_id      = {b, partial[23:16]};
          rec.company_id    = partial[15:0];
          vend_left_next    = vend_left - 8'd1;
          if (vend_left == 8'd1) begin
            cur_elem_next = (cur_elem != cdp0_pkg::ELEMENT_MAX) ? cur_elem + 8'd1 : cur_elem;
            phase_next    = cdp0_pkg::PH_LOC;
          end
        end
      end
      default: begin
        // Location field, and phase codes that are never entered.
        phase_next = cdp0_pkg::PH_LOC;
        if (bif == 2'd0) begin
          bif_next = 2'd1;
        end else begin
          bif_next       = 2'd0;
          kept_slot_next = 8'd0;
          sig_left_next  = 8'd0;
          vend_left_next = 8'd0;
          phase_next     = cdp0_pkg::PH_NUMS;
        end
      end
    endcase

    rec.feature_bits = features_next;

    if (item.last_byte) begin
      clean     = (phase_next == cdp0_pkg::PH_LOC) && (bif_next == 2'd0);
      end_count = cur_elem_next;
      if (!clean && phase_next != cdp0_pkg::PH_HEADER &&
          end_count != cdp0_pkg::ELEMENT_MAX) begin
        end_count = end_count + 8'd1;
      end
      if (phase_next == cdp0_pkg::PH_HEADER) begin
        end_count = 8'd0;
      end
      fin.record_kind   = cdp0_pkg::KIND_END;
      fin.feature_bits  = features_next;
      fin.element_count = end_count;
      fin.malformed     = !clean;
      fin.last_result   = 1'b1;

      // The page is done; start over for the next one.
      byte_pos_next  = 8'd0;
      phase_next     = cdp0_pkg::PH_HEADER;
      cur_elem_next  = 8'd0;
      sig_left_next  = 8'd0;
      vend_left_next = 8'd0;
      bif_next       = 2'd0;
      partial_next   = 24'd0;
      kept_slot_next = 8'd0;
      features_next  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos  <= 8'd0;
      phase     <= cdp0_pkg::PH_HEADER;
      cur_elem  <= 8'd0;
      sig_left  <= 8'd0;
      vend_left <= 8'd0;
      bif       <= 2'd0;
      partial   <= 24'd0;
      kept_slot <= 8'd0;
      features  <= 16'd0;
    end else if (step) begin
      byte_pos  <= byte_pos_next;
      phase     <= phase_next;
      cur_elem  <= cur_elem_next;
      sig_left  <= sig_left_next;
      vend_left <= vend_left_next;
      bif       <= bif_next;
      partial   <= partial_next;
      kept_slot <= kept_slot_next;
      features  <= features_next;
    end
  end

  assign push.rec_vld = step && rec_vld;
  assign push.fin_vld = step && item.last_byte;
  assign push.rec     = rec;
  assign push.fin     = fin;

  // A marked last byte leaves the parser in its start-of-page state.
  a_page_restart: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> phase == cdp0_pkg::PH_HEADER && byte_pos == 8'd0 &&
                               cur_elem == 8'd0 && features == 16'd0)
    else $error("parser state not cleared after end of page");

  // Parse state only moves on a step.
  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(kept_slot) && $stable(byte_pos) && $stable(bif))
    else $error("parser state changed without a step");

endmodule

// ===== sv/cdp0_fifo.sv =====
// Result queue of the composition data page 0 parser: takes up to two records
// per cycle and hands out one. Depends on cdp0_pkg.
module cdp0_fifo (
  input  logic            clk,
  input  logic            rst,
  input  cdp0_pkg::push_t push,
  input  logic            pop,
  output cdp0_pkg::out_t  head,
  output logic            nonempty,
  output logic            room
);

  cdp0_pkg::out_t                     mem [cdp0_pkg::FIFO_DEPTH];
  logic [cdp0_pkg::FIFO_PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [cdp0_pkg::FIFO_PTR_W-1:0]    wr_ptr_1, fin_ptr;
  logic [cdp0_pkg::FIFO_CNT_W-1:0]    count, count_after_pop, n_push;

  assign wr_ptr_1        = wr_ptr + cdp0_pkg::FIFO_PTR_W'(1);
  assign fin_ptr         = push.rec_vld ? wr_ptr_1 : wr_ptr;
  assign n_push          = cdp0_pkg::FIFO_CNT_W'(push.rec_vld) +
                           cdp0_pkg::FIFO_CNT_W'(push.fin_vld);
  assign count_after_pop = count - cdp0_pkg::FIFO_CNT_W'(pop);
  assign room            = count_after_pop <= cdp0_pkg::FIFO_CNT_W'(cdp0_pkg::FIFO_DEPTH - 2);
  assign nonempty        = count != '0;
  assign head            = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.rec_vld) begin
      mem[wr_ptr] <= push.rec;
    end
    if (push.fin_vld) begin
      mem[fin_ptr] <= push.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + cdp0_pkg::FIFO_PTR_W'(n_push);
      rd_ptr <= rd_ptr + cdp0_pkg::FIFO_PTR_W'(pop);
      count  <= count_after_pop + n_push;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= cdp0_pkg::FIFO_CNT_W'(cdp0_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.rec_vld || push.fin_vld |-> room)
    else $error("record pushed without room for two entries");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("result queue read while empty");

endmodule

// ===== sv/composition_data_page0_parser.sv =====
// Top level of the composition data page 0 parser.
// Depends on cdp0_pkg, cdp0_core and cdp0_fifo.
//
// The block takes a mesh composition data page 0 one byte per transaction on
// the byte channel (byte_valid, byte_ready, byte_data), with last_byte set on
// the final byte of the page. It returns records on the rec channel
// (rec_valid, rec_ready, rec_data): the feature word once the header is in,
// one record per kept SIG model and per vendor model, and an end of page
// record after the marked last byte, which also carries the element count
// and the malformed flag.
// An accepted byte first lands in an input register; from there the parse
// step updates the state and writes its records into a four-entry result
// queue, from which they are offered. One byte is taken per cycle for as
// long as the receiver keeps up; a byte that yields two records (the last
// one of a page) writes both at once, and the queue hands them out one at a
// time. The parse step runs only when the queue has room for two records,
// so a stalled receiver fills the queue and then holds byte_ready low;
// nothing is dropped. Reset clears the parse state, the input register and
// the queue; the first byte after reset is header byte 0 of a page.
module composition_data_page0_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_ready,
  input  cdp0_pkg::in_t  byte_data,
  output logic           rec_valid,
  input  logic           rec_ready,
  output cdp0_pkg::out_t rec_data
);

  cdp0_pkg::in_t   in_q;
  logic            in_vld_q;
  logic            step;
  logic            room;
  logic            pop;
  cdp0_pkg::push_t push;

  // The held byte is parsed once the queue can take both possible records.
  assign step       = in_vld_q && room;
  assign byte_ready = !in_vld_q || step;
  assign pop        = rec_valid && rec_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_q <= 1'b0;
    end else if (byte_ready) begin
      in_vld_q <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_q <= byte_data;
    end
  end

  cdp0_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_q),
    .push (push)
  );

  cdp0_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .head     (rec_data),
    .nonempty (rec_valid),
    .room     (room)
  );

endmodule

// ===== bench/composition_data_page0_parser_tb.sv =====
// Testbench for composition_data_page0_parser: pages of composition data go in,
// and the records that come out are checked against a byte-level parse model.
// Depends on cdp0_pkg and the parser RTL.
module composition_data_page0_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound on the whole run, far above the slowest correct run.
  localparam int CYCLE_LIMIT = 600000;
  // Random bytes beyond the directed table.
  localparam int RANDOM_BYTES = 600;
  localparam int DIRECTED_ROWS = 27;
  // Bytes accepted before the receiver goes quiet for a long stretch.
  localparam int HOLD_AFTER_BYTES = 200;
  localparam int HOLD_CYCLES = 90;

  // One transaction on the byte channel. Rows marked typed carry the record
  // that the byte must produce last, written out by hand.
  typedef struct packed {
    cdp0_pkg::in_t  item;
    logic           typed;
    cdp0_pkg::out_t want;
  } plan_row_t;

  localparam cdp0_pkg::out_t NO_RECORD = '0;
  // Page cut short in the middle of the header.
  localparam cdp0_pkg::out_t END_CUT_HEADER =
    {cdp0_pkg::KIND_END, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 8'd0, 1'b1, 1'b1};
  // Feature word with every bit set.
  localparam cdp0_pkg::out_t FEATURES_ALL =
    {cdp0_pkg::KIND_FEATURES, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'hFFFF, 8'd0, 1'b0, 1'b0};
  // Largest SIG model id, first kept model of element 1.
  localparam cdp0_pkg::out_t SIG_TOP_ID =
    {cdp0_pkg::KIND_SIG, 8'd1, 8'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd0, 1'b0, 1'b0};
  // Two complete elements, page ends on an element boundary.
  localparam cdp0_pkg::out_t END_CLEAN_TWO =
    {cdp0_pkg::KIND_END, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'hFFFF, 8'd2, 1'b0, 1'b1};

  // Directed pages. The first is a single marked byte, so the page dies in the
  // header. The second has an all-ones feature word, an empty element, and an
  // element with a dropped foundation model, a kept SIG model with the top id,
  // and one vendor model whose last byte closes the page.
  localparam plan_row_t DIRECTED [DIRECTED_ROWS] = '{
    {8'h00, 1'b1, 1'b1, END_CUT_HEADER},
    {8'hFF, 1'b0, 1'b0, NO_RECORD},
    {8'h00, 1'b0, 1'b0, NO_RECORD},
    {8'hFF, 1'b0, 1'b0, NO_RECORD},
    {8'h00, 1'b0, 1'b0, NO_RECORD},
    {8'h5A, 1'b0, 1'b0, NO_RECORD},
    {8'hA5, 1'b0, 1'b0, NO_RECORD},
    {8'hFF, 1'b0, 1'b0, NO_RECORD},
    {8'h00, 1'b0, 1'b0, NO_RECORD},
    {8'hFF, 1'b0, 1'b0, NO_RECORD},
    {8'hFF, 1'b0, 1'b1, FEATURES_ALL},
    {8'hFF, 1'b0, 1'b0, NO_RECORD},
    {8'h00, 1'b0, 1'b0, NO_RECORD},
    {8'h00, 1'b0, 1'b0, NO_RECORD},
    {8'h00, 1'b0, 1'b0, NO_RECORD},
    {8'h00, 1'b0, 1'b0, NO_RECORD},
    {8'hFF, 1'b0, 1'b0, NO_RECORD},
    {8'h02, 1'b0, 1'b0, NO_RECORD},
    {8'h01, 1'b0, 1'b0, NO_RECORD},
    {8'h03, 1'b0, 1'b0, NO_RECORD},
    {8'h00, 1'b0, 1'b0, NO_RECORD},
    {8'hFF, 1'b0, 1'b0, NO_RECORD},
    {8'hFF, 1'b0, 1'b1, SIG_TOP_ID},
    {8'hFF, 1'b0, 1'b0, NO_RECORD},
    {8'hFF, 1'b0, 1'b0, NO_RECORD},
    {8'h00, 1'b0, 1'b0, NO_RECORD},
    {8'h00, 1'b1, 1'b1, END_CLEAN_TWO}
  };

  logic           clk;
  logic           rst;
  logic           byte_valid;
  logic           byte_ready;
  cdp0_pkg::in_t  byte_data;
  logic           rec_valid;
  logic           rec_ready;
  cdp0_pkg::out_t rec_data;

  composition_data_page0_parser dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_data (byte_data),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_data  (rec_data)
  );

  plan_row_t      byte_plan[$];
  cdp0_pkg::out_t predicted_records[$];
  int             mismatch_count = 0;
  int             cycle_count = 0;
  int             bytes_taken = 0;
  bit             long_hold_done = 0;

  // Parser state as the testbench sees it.
  cdp0_pkg::phase_t parse_state;
  logic [7:0]       hdr_pos;
  logic [7:0]       cur_elem;
  logic [7:0]       sigs_left;
  logic [7:0]       vendors_left;
  logic [1:0]       field_idx;
  logic [23:0]      gathered;
  logic [7:0]       next_slot;
  logic [15:0]      feature_word;

  function automatic void clear_parser();
    parse_state = cdp0_pkg::PH_HEADER;
    hdr_pos = '0;
    cur_elem = '0;
    sigs_left = '0;
    vendors_left = '0;
    field_idx = '0;
    gathered = '0;
    next_slot = '0;
    feature_word = '0;
  endfunction

  // Every record carries the feature word as it stands when the record is made.
  function automatic cdp0_pkg::out_t make_record(logic [1:0] kind, logic [7:0] elem_i,
                                                 logic [7:0] slot_i, logic [15:0] mid,
                                                 logic [15:0] cid, logic [7:0] cnt,
                                                 logic bad, logic fin);
    cdp0_pkg::out_t r;
    r.record_kind = kind;
    r.element_index = elem_i;
    r.model_slot = slot_i;
    r.model_id = mid;
    r.company_id = cid;
    r.feature_bits = feature_word;
    r.element_count = cnt;
    r.malformed = bad;
    r.last_result = fin;
    return r;
  endfunction

  // The element counter sticks at its maximum on very long pages.
  function automatic void close_element();
    if (cur_elem != cdp0_pkg::ELEMENT_MAX) cur_elem++;
    parse_state = cdp0_pkg::PH_LOC;
    field_idx = '0;
  endfunction

  // Advances the parse by one byte and queues the records it yields.
  function automatic void parse_byte(cdp0_pkg::in_t item);
    logic [7:0]  b;
    logic [15:0] id;
    logic        clean;
    logic [7:0]  cnt;
    b = item.data_byte;
    case (parse_state)
      cdp0_pkg::PH_HEADER: begin
        if (hdr_pos == cdp0_pkg::FEATURE_LO_POS) begin
          feature_word = {8'h00, b};
        end else if (hdr_pos == cdp0_pkg::FEATURE_HI_POS) begin
          feature_word[15:8] = b;
          predicted_records.push_back(make_record(cdp0_pkg::KIND_FEATURES, 8'd0, 8'd0,
                                                  16'd0, 16'd0, 8'd0, 1'b0, 1'b0));
          parse_state = cdp0_pkg::PH_LOC;
          field_idx = '0;
        end
        hdr_pos++;
      end
      cdp0_pkg::PH_NUMS: begin
        sigs_left = b;
        parse_state = cdp0_pkg::PH_NUMV;
      end
      cdp0_pkg::PH_NUMV: begin
        vendors_left = b;
        field_idx = '0;
        if (sigs_left != 0) parse_state = cdp0_pkg::PH_SIG;
        else if (vendors_left != 0) parse_state = cdp0_pkg::PH_VEND;
        else close_element();
      end
      cdp0_pkg::PH_SIG: begin
        if (field_idx == 0) begin
          gathered = {16'h0000, b};
          field_idx = 2'd1;
        end else begin
          id = {b, gathered[7:0]};
          field_idx = '0;
          if (id > cdp0_pkg::MAX_FOUNDATION_ID) begin
            predicted_records.push_back(make_record(cdp0_pkg::KIND_SIG, cur_elem, next_slot,
                                                    id, 16'd0, 8'd0, 1'b0, 1'b0));
            next_slot++;
          end
          sigs_left--;
          if (sigs_left == 0) begin
            if (vendors_left != 0) parse_state = cdp0_pkg::PH_VEND;
            else close_element();
          end
        end
      end
      cdp0_pkg::PH_VEND: begin
        if (field_idx < 3) begin
          gathered[8*field_idx +: 8] = b;
          field_idx++;
        end else begin
          field_idx = '0;
          predicted_records.push_back(make_record(cdp0_pkg::KIND_VENDOR, cur_elem, 8'd0,
                                                  {b, gathered[23:16]}, gathered[15:0],
                                                  8'd0, 1'b0, 1'b0));
          vendors_left--;
          if (vendors_left == 0) close_element();
        end
      end
      default: begin
        // Two location bytes, then a fresh element starts with its counts.
        parse_state = cdp0_pkg::PH_LOC;
        if (field_idx == 0) begin
          field_idx = 2'd1;
        end else begin
          field_idx = '0;
          next_slot = '0;
          sigs_left = '0;
          vendors_left = '0;
          parse_state = cdp0_pkg::PH_NUMS;
        end
      end
    endcase

    if (item.last_byte) begin
      // A page is clean only when it stops between elements. A partial element
      // still counts, a page cut in the header reports no elements at all.
      clean = (parse_state == cdp0_pkg::PH_LOC) && (field_idx == 0);
      cnt = cur_elem;
      if (!clean && parse_state != cdp0_pkg::PH_HEADER && cnt != cdp0_pkg::ELEMENT_MAX) cnt++;
      if (parse_state == cdp0_pkg::PH_HEADER) cnt = '0;
      predicted_records.push_back(make_record(cdp0_pkg::KIND_END, 8'd0, 8'd0, 16'd0, 16'd0,
                                              cnt, !clean, 1'b1));
      clear_parser();
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_plan_byte(logic [7:0] b, logic fin);
    byte_plan.push_back({b, fin, 1'b0, NO_RECORD});
  endfunction

  // Builds one well-formed page with random content. Pages are sometimes cut
  // at a random byte to exercise every kind of truncation.
  function automatic void queue_page(int elements);
    logic [7:0]  pg[$];
    logic [15:0] sig_id;
    int          nsig;
    int          nvend;
    int          keep;
    for (int i = 0; i < 10; i++) pg.push_back(rand_byte());
    for (int e = 0; e < elements; e++) begin
      pg.push_back(rand_byte());
      pg.push_back(rand_byte());
      nsig = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      nvend = $urandom_range(0, 2);
      pg.push_back(nsig[7:0]);
      pg.push_back(nvend[7:0]);
      repeat (nsig) begin
        // Lean on ids around the foundation range, where models are dropped.
        sig_id = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 5))
                                             : 16'($urandom_range(0, 65535));
        pg.push_back(sig_id[7:0]);
        pg.push_back(sig_id[15:8]);
      end
      repeat (4 * nvend) pg.push_back(rand_byte());
    end
    if ($urandom_range(0, 3) == 0) keep = $urandom_range(1, pg.size());
    else keep = pg.size();
    for (int i = 0; i < keep; i++) add_plan_byte(pg[i], i == keep - 1);
  endfunction

  // Short runs of arbitrary bytes; any count byte can land here.
  function automatic void queue_noise();
    int len;
    len = $urandom_range(1, 30);
    for (int i = 0; i < len; i++) add_plan_byte(rand_byte(), i == len - 1);
  endfunction

  // Idle lengths: mostly none or short, a few long, and every fourth stretch of
  // fifty ticks runs with no idling at all.
  function automatic int idle_len(int tick);
    int r;
    if ((tick / 50) % 4 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing record ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Receiver side. rec_ready changes at the falling edge. Short random stalls
  // throughout, plus one long hold-off once the random traffic is flowing, so
  // the result queue fills and the parser has to push back on byte_ready.
  initial begin
    int stall;
    stall = 0;
    rec_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!long_hold_done && bytes_taken >= HOLD_AFTER_BYTES) begin
        stall = HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (stall > 0) begin
        rec_ready = 1'b0;
        stall--;
      end else begin
        rec_ready = 1'b1;
        stall = idle_len(cycle_count);
      end
      @(negedge clk);
    end
  end

  // Every record transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    cdp0_pkg::out_t want;
    if (!rst && rec_valid && rec_ready) begin
      if (predicted_records.size() == 0) begin
        $error("record_kind: expected no record, got 0x%0h", rec_data.record_kind);
        mismatch_count++;
      end else begin
        want = predicted_records.pop_front();
        check_field("record_kind", 16'(want.record_kind), 16'(rec_data.record_kind));
        check_field("element_index", 16'(want.element_index), 16'(rec_data.element_index));
        check_field("model_slot", 16'(want.model_slot), 16'(rec_data.model_slot));
        check_field("model_id", want.model_id, rec_data.model_id);
        check_field("company_id", want.company_id, rec_data.company_id);
        check_field("feature_bits", want.feature_bits, rec_data.feature_bits);
        check_field("element_count", 16'(want.element_count), 16'(rec_data.element_count));
        check_field("malformed", 16'(want.malformed), 16'(rec_data.malformed));
        check_field("last_result", 16'(want.last_result), 16'(rec_data.last_result));
      end
    end
  end

  // Sender side and end of run.
  initial begin
    int gap;
    plan_row_t row;
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_data = '0;
    clear_parser();

    for (int i = 0; i < DIRECTED_ROWS; i++) byte_plan.push_back(DIRECTED[i]);
    // Random pages mixed with runs of noise.
    while (byte_plan.size() < DIRECTED_ROWS + RANDOM_BYTES) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_noise();
      end else begin
        queue_page($urandom_range(0, 4));
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Each byte is offered at a falling edge and held until a rising edge sees
    // byte_ready. The prediction is made at that same edge, before the record it
    // predicts can leave the block.
    for (int i = 0; i < byte_plan.size(); i++) begin
      row = byte_plan[i];
      gap = idle_len(bytes_taken);
      if (gap > 0) begin
        byte_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      byte_valid = 1'b1;
      byte_data = row.item;
      do @(posedge clk); while (byte_ready !== 1'b1);
      parse_byte(row.item);
      if (row.typed) predicted_records[predicted_records.size() - 1] = row.want;
      bytes_taken++;
      @(negedge clk);
    end
    byte_valid = 1'b0;

    // Drain, then keep watching for any stray record before the verdict.
    while (predicted_records.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
